// File: rtl/core/d2q_pkg.sv
// Shared types, widths and lattice constants for the D2Q9 TRT collision core.
// No dependencies; every other file in rtl/core refers to it by scoped names.
package d2q_pkg;

	localparam int NDIR   = 9;
	localparam int NCLASS = 3;
	localparam int Q_W    = 32;   // Q3.28 words
	localparam int TAU_W  = 31;   // unsigned Q0.31 rates
	localparam int EU_W   = 34;   // e.u, sum of two words
	localparam int SQ_W   = 38;   // floor((e.u)^2 / 2^28)
	localparam int UU_W   = 37;   // u.u, up to 2^35 when both components are at the minimum
	localparam int P_W    = 34;   // saturated polynomial
	localparam int PX_W   = 48;   // polynomial before saturation
	localparam int RW_W   = 32;   // density times weight
	localparam int EQ_W   = 38;   // equilibrium
	localparam int DS_W   = 40;   // differences before saturation
	localparam int D_W    = 33;   // saturated differences
	localparam int SUM_W  = 36;   // relaxed result before saturation
	localparam int IDX_W  = 4;
	localparam int FRAC_W = 28;

	localparam int DIR_X  [NDIR] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
	localparam int DIR_Y  [NDIR] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
	localparam int MIRROR [NDIR] = '{0, 3, 4, 1, 2, 7, 8, 5, 6};
	localparam int WCLASS [NDIR] = '{0, 1, 1, 1, 1, 2, 2, 2, 2};
	localparam logic signed [30:0] WGT_Q30 [NCLASS] = '{31'sd477218588, 31'sd119304647,
		31'sd29826162};

	localparam logic [TAU_W-1:0] INV_TAU_SYM_RST  = 31'd2083477898;
	localparam logic [TAU_W-1:0] INV_TAU_ANTI_RST = 31'd64004676;

	typedef logic signed [Q_W-1:0] q28_t;

	typedef enum logic [IDX_W-1:0] {
		REG_INV_TAU_SYM  = 4'd0,
		REG_INV_TAU_ANTI = 4'd1
	} cfg_reg_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} stage_en_t;

endpackage

// File: rtl/core/d2q_eq_lane.sv
// One direction lane: e.u, squared term, polynomial and equilibrium (stages 1-3).
// Depends on d2q_pkg.
module d2q_eq_lane #(
	parameter int DIR = 0
) (
	input  logic                               clk,
	input  d2q_pkg::stage_en_t                 en,
	input  d2q_pkg::q28_t                      ux,
	input  d2q_pkg::q28_t                      uy,
	input  d2q_pkg::q28_t                      f,
	input  logic signed [d2q_pkg::UU_W-1:0]    uu_s1,
	input  logic signed [d2q_pkg::RW_W-1:0]    rw_s2,
	output logic signed [d2q_pkg::EQ_W-1:0]    eq_s3,
	output d2q_pkg::q28_t                      f_s3
);

	localparam int EUW = d2q_pkg::EU_W;
	localparam int PXW = d2q_pkg::PX_W;
	localparam logic signed [PXW-1:0] P_HI = (PXW'(1) <<< (d2q_pkg::P_W - 1)) - PXW'(1);
	localparam logic signed [PXW-1:0] P_LO = -(PXW'(1) <<< (d2q_pkg::P_W - 1));
	localparam logic signed [PXW-1:0] ONE  = PXW'(1) <<< d2q_pkg::FRAC_W;

	logic signed [EUW-1:0]              ex, ey, eu;
	logic signed [2*EUW-1:0]            sq_full;
	logic signed [EUW-1:0]              eu_s1;
	logic signed [d2q_pkg::SQ_W-1:0]    sq_s1;
	d2q_pkg::q28_t                      f_s1, f_s2;
	logic signed [PXW-1:0]              px;
	logic signed [d2q_pkg::P_W-1:0]     p_s2;
	logic signed [d2q_pkg::RW_W+d2q_pkg::P_W-1:0] prod;

	always_comb begin
		ex = '0;
		ey = '0;
		if (d2q_pkg::DIR_X[DIR] == 1) ex = EUW'(ux);
		else if (d2q_pkg::DIR_X[DIR] == -1) ex = -EUW'(ux);
		if (d2q_pkg::DIR_Y[DIR] == 1) ey = EUW'(uy);
		else if (d2q_pkg::DIR_Y[DIR] == -1) ey = -EUW'(uy);
		eu = ex + ey;
		sq_full = eu * eu;
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			eu_s1 <= eu;
			sq_s1 <= sq_full[d2q_pkg::SQ_W+d2q_pkg::FRAC_W-1:d2q_pkg::FRAC_W];
			f_s1  <= f;
		end
	end

	// P = 1 + 3 e.u + floor((9 (e.u)^2 - 3 u.u) / 2), then clamped.
	always_comb begin
		px = ONE + PXW'(3) * PXW'(eu_s1)
			+ ((PXW'(9) * PXW'(sq_s1) - PXW'(3) * PXW'(uu_s1)) >>> 1);
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			if (px > P_HI) p_s2 <= P_HI[d2q_pkg::P_W-1:0];
			else if (px < P_LO) p_s2 <= P_LO[d2q_pkg::P_W-1:0];
			else p_s2 <= px[d2q_pkg::P_W-1:0];
			f_s2 <= f_s1;
		end
	end

	assign prod = rw_s2 * p_s2;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			eq_s3 <= prod[d2q_pkg::EQ_W+d2q_pkg::FRAC_W-1:d2q_pkg::FRAC_W];
			f_s3  <= f_s2;
		end
	end

endmodule

// File: rtl/core/d2q_relax_lane.sv
// Pair merge and relaxation for one direction with its opposite (stages 4-5).
// Depends on d2q_pkg.
module d2q_relax_lane (
	input  logic                               clk,
	input  d2q_pkg::stage_en_t                 en,
	input  logic signed [d2q_pkg::EQ_W-1:0]    eq_own,
	input  logic signed [d2q_pkg::EQ_W-1:0]    eq_opp,
	input  d2q_pkg::q28_t                      f_own,
	input  d2q_pkg::q28_t                      f_opp,
	input  logic [d2q_pkg::TAU_W-1:0]          inv_tau_sym,
	input  logic [d2q_pkg::TAU_W-1:0]          inv_tau_anti,
	output d2q_pkg::q28_t                      post_s5
);

	localparam int DSW = d2q_pkg::DS_W;
	localparam int DW  = d2q_pkg::D_W;
	localparam int SW  = d2q_pkg::SUM_W;
	localparam int MW  = DW + d2q_pkg::TAU_W + 1;
	localparam logic signed [DSW-1:0] D_HI = (DSW'(1) <<< (DW - 1)) - DSW'(1);
	localparam logic signed [DSW-1:0] D_LO = -(DSW'(1) <<< (DW - 1));
	localparam logic signed [SW-1:0]  R_HI = (SW'(1) <<< (d2q_pkg::Q_W - 1)) - SW'(1);
	localparam logic signed [SW-1:0]  R_LO = -(SW'(1) <<< (d2q_pkg::Q_W - 1));

	logic signed [DSW-1:0] ds, da;
	logic signed [DW-1:0]  ds_s4, da_s4;
	d2q_pkg::q28_t         f_s4;
	logic signed [MW-1:0]  ms, ma;
	logic signed [SW-1:0]  r;

	function automatic logic signed [DW-1:0] clamp_d(input logic signed [DSW-1:0] v);
		if (v > D_HI) return D_HI[DW-1:0];
		else if (v < D_LO) return D_LO[DW-1:0];
		else return v[DW-1:0];
	endfunction

	always_comb begin
		ds = (DSW'(eq_own) + DSW'(eq_opp)) - (DSW'(f_own) + DSW'(f_opp));
		da = (DSW'(eq_own) - DSW'(eq_opp)) - (DSW'(f_own) - DSW'(f_opp));
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			ds_s4 <= clamp_d(ds);
			da_s4 <= clamp_d(da);
			f_s4  <= f_own;
		end
	end

	always_comb begin
		ms = MW'(ds_s4) * MW'($signed({1'b0, inv_tau_sym}));
		ma = MW'(da_s4) * MW'($signed({1'b0, inv_tau_anti}));
		r  = SW'(f_s4) + SW'(ms >>> 31) + SW'(ma >>> 31);
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			if (r > R_HI) post_s5 <= R_HI[d2q_pkg::Q_W-1:0];
			else if (r < R_LO) post_s5 <= R_LO[d2q_pkg::Q_W-1:0];
			else post_s5 <= r[d2q_pkg::Q_W-1:0];
		end
	end

endmodule

// File: rtl/core/d2q9_trt_collision_core.sv
// D2Q9 two-relaxation-time collision core: one cell word in, nine post-collision
// distributions out, through the five-stage lane pipeline; throughput is one cell
// per cycle while out_ready is high.
// Each stage stalls only when it is full and the stage after it cannot take a word.
// Reset (arst_n low, asynchronous) empties the pipeline and restores the rates.
// Depends on d2q_pkg, d2q_eq_lane and d2q_relax_lane.
module d2q9_trt_collision_core #(
	parameter logic [d2q_pkg::TAU_W-1:0] SYM_RST  = d2q_pkg::INV_TAU_SYM_RST,
	parameter logic [d2q_pkg::TAU_W-1:0] ANTI_RST = d2q_pkg::INV_TAU_ANTI_RST
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [d2q_pkg::IDX_W-1:0]    cfg_index,
	input  logic [31:0]                  cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  d2q_pkg::q28_t                dist_0, dist_1, dist_2, dist_3, dist_4,
	input  d2q_pkg::q28_t                dist_5, dist_6, dist_7, dist_8,
	input  d2q_pkg::q28_t                density,
	input  d2q_pkg::q28_t                vel_x,
	input  d2q_pkg::q28_t                vel_y,
	output logic                         out_valid,
	input  logic                         out_ready,
	output d2q_pkg::q28_t                post_0, post_1, post_2, post_3, post_4,
	output d2q_pkg::q28_t                post_5, post_6, post_7, post_8
);

	localparam int N = d2q_pkg::NDIR;

	logic [d2q_pkg::TAU_W-1:0] inv_tau_sym_q, inv_tau_anti_q;
	logic                      v_s1, v_s2, v_s3, v_s4, v_s5;
	d2q_pkg::stage_en_t        en;

	d2q_pkg::q28_t dist_w [N];
	d2q_pkg::q28_t post [N];
	logic signed [d2q_pkg::EQ_W-1:0] eq_s3 [N];
	d2q_pkg::q28_t f_s3 [N];

	// Rates are written through their own channel, which is always ready.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_tau_sym_q  <= SYM_RST;
			inv_tau_anti_q <= ANTI_RST;
		end else if (cfg_valid) begin
			if (cfg_index == d2q_pkg::REG_INV_TAU_SYM)
				inv_tau_sym_q <= cfg_data[d2q_pkg::TAU_W-1:0];
			else if (cfg_index == d2q_pkg::REG_INV_TAU_ANTI)
				inv_tau_anti_q <= cfg_data[d2q_pkg::TAU_W-1:0];
		end
	end

	// Each stage loads when it is empty or its word moves on in the same cycle,
	// so bubbles collapse and input keeps flowing while the output waits.
	always_comb begin
		en.s5 = !v_s5 || out_ready;
		en.s4 = !v_s4 || en.s5;
		en.s3 = !v_s3 || en.s4;
		en.s2 = !v_s2 || en.s3;
		en.s1 = !v_s1 || en.s2;
	end

	assign in_ready  = en.s1;
	assign out_valid = v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= in_valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
			if (en.s5) v_s5 <= v_s4;
		end
	end

	// Shared terms: the velocity squares and the density times each weight class.
	logic signed [2*d2q_pkg::Q_W-1:0]  sqx, sqy;
	logic signed [d2q_pkg::UU_W-1:0]   sqx_s1, sqy_s1, uu_s1;
	logic signed [d2q_pkg::Q_W+31-1:0] rwp [d2q_pkg::NCLASS];
	logic signed [d2q_pkg::RW_W-1:0]   rw_s1 [d2q_pkg::NCLASS];
	logic signed [d2q_pkg::RW_W-1:0]   rw_s2 [d2q_pkg::NCLASS];

	always_comb begin
		sqx = vel_x * vel_x;
		sqy = vel_y * vel_y;
		for (int c = 0; c < d2q_pkg::NCLASS; c++)
			rwp[c] = density * d2q_pkg::WGT_Q30[c];
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			sqx_s1 <= d2q_pkg::UU_W'(sqx[2*d2q_pkg::Q_W-1:d2q_pkg::FRAC_W]);
			sqy_s1 <= d2q_pkg::UU_W'(sqy[2*d2q_pkg::Q_W-1:d2q_pkg::FRAC_W]);
			for (int c = 0; c < d2q_pkg::NCLASS; c++)
				rw_s1[c] <= rwp[c][d2q_pkg::RW_W+30-1:30];
		end
		if (en.s2) begin
			for (int c = 0; c < d2q_pkg::NCLASS; c++)
				rw_s2[c] <= rw_s1[c];
		end
	end

	assign uu_s1 = sqx_s1 + sqy_s1;

	assign dist_w[0] = dist_0;
	assign dist_w[1] = dist_1;
	assign dist_w[2] = dist_2;
	assign dist_w[3] = dist_3;
	assign dist_w[4] = dist_4;
	assign dist_w[5] = dist_5;
	assign dist_w[6] = dist_6;
	assign dist_w[7] = dist_7;
	assign dist_w[8] = dist_8;

	// Nine equilibrium lanes, then nine relaxation lanes that each merge a
	// direction with its opposite.
	for (genvar g = 0; g < N; g++) begin : g_lane
		d2q_eq_lane #(.DIR(g)) u_eq (
			.clk   (clk),
			.en    (en),
			.ux    (vel_x),
			.uy    (vel_y),
			.f     (dist_w[g]),
			.uu_s1 (uu_s1),
			.rw_s2 (rw_s2[d2q_pkg::WCLASS[g]]),
			.eq_s3 (eq_s3[g]),
			.f_s3  (f_s3[g])
		);

		d2q_relax_lane u_relax (
			.clk          (clk),
			.en           (en),
			.eq_own       (eq_s3[g]),
			.eq_opp       (eq_s3[d2q_pkg::MIRROR[g]]),
			.f_own        (f_s3[g]),
			.f_opp        (f_s3[d2q_pkg::MIRROR[g]]),
			.inv_tau_sym  (inv_tau_sym_q),
			.inv_tau_anti (inv_tau_anti_q),
			.post_s5      (post[g])
		);
	end

	assign post_0 = post[0];
	assign post_1 = post[1];
	assign post_2 = post[2];
	assign post_3 = post[3];
	assign post_4 = post[4];
	assign post_5 = post[5];
	assign post_6 = post[6];
	assign post_7 = post[7];
	assign post_8 = post[8];

endmodule
